FILE: hdl/wesd_pkg.sv
// Package for the wheel encoder speed and distance block: types, field widths,
// command and register codes, and reset values. No dependencies.
package wesd_pkg;

    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int STEP_W     = 16;
    localparam int DIST_W     = 48;
    localparam int SPEED_W    = 26;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // Input tdata: wheel, rise flag, fall flag, time_us (35 bits, padded to 40).
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 1;
    // Output tdata: wheel_id, pulse_total, duration_us, distance_um, speed_mm_s
    // (139 bits, padded to 144).
    localparam int OUT_DATA_W = 144;
    localparam int OUT_USER_W = 1;

    // Micrometres per microsecond to millimetres per second.
    localparam int STEP_SCALE = 1000;
    localparam int DIV_STEPS  = SPEED_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd10500;
    localparam logic [TIME_W-1:0] IDLE_RESET = 32'd2000000;

    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    localparam logic KIND_PULSE = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_STEP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_FINISH
    } state_t;

endpackage

FILE: hdl/wheel_encoder_speed_distance.sv
// Wheel encoder speed and distance measurer: top level with sequencer,
// per-wheel state and a shared shift-subtract divider. Uses wesd_pkg.
//
// Usage: each input transfer on s_axis carries either an edge event (tuser 0)
// or a poll (tuser 1) for one wheel, with a microsecond timestamp. The first
// edge of a pair stores its time; the second gives a pulse measurement on
// m_axis (tuser 0) with duration, pulse total, distance and speed. A poll
// gives one total report (tuser 1) once the idle interval has passed since
// the last pulse. Items that give no result are simply absorbed.
// Timing: one item is taken, then s_axis_tready stays low while it is worked
// on. A pulse measurement goes through latch, lookup of the wheel state, 26
// iterations of the restoring divider that forms the speed, and a final step
// that multiplies out the distance into the output register. Zero duration
// and polls skip the divider; items with no result end after the lookup.
// A finished result sits in the output register, so the next item is taken
// while it waits. If the receiver stalls and a second result is ready, the
// sequencer holds it until the output register frees up. Reset clears all
// wheel state and loads step_um = 10500, idle 2000000 us. The user must write
// the config port (cfg_we, cfg_index, cfg_wdata) only when idle; not enforced.
module wheel_encoder_speed_distance #(
    parameter int NUM_WHEELS = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] wheel, [1] rise flag, [2] fall flag, [34:3] time_us, rest zero
    input  logic [wesd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] cmd
    input  logic [wesd_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] wheel_id, [32:1] pulse_total, [64:33] duration_us,
    // [112:65] distance_um, [138:113] speed_mm_s, rest zero
    output logic [wesd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [0] kind
    output logic [wesd_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    input  logic                              cfg_we,
    input  logic [wesd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wesd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import wesd_pkg::*;

    localparam int IDX_W = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

    state_t state_reg, state_next;

    // Latched input item.
    logic              cmd_reg;
    logic              wheel_reg;
    logic              edge_any_reg;
    logic [TIME_W-1:0] time_reg;

    // Configuration.
    logic [STEP_W-1:0] step_reg;
    logic [TIME_W-1:0] idle_reg;

    // Per-wheel state.
    logic [NUM_WHEELS-1:0] pending_reg;
    logic [NUM_WHEELS-1:0] due_reg;
    logic [TIME_W-1:0]     start_reg [NUM_WHEELS];
    logic [COUNT_W-1:0]    count_reg [NUM_WHEELS];
    logic [TIME_W-1:0]     last_reg  [NUM_WHEELS];

    // Result under construction and divider.
    logic                 kind_reg;
    logic [COUNT_W-1:0]   total_reg;
    logic [TIME_W-1:0]    dur_reg;
    logic [SPEED_W-1:0]   quot_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    // Output register.
    logic                out_valid_reg;
    logic                out_kind_reg;
    logic                out_wheel_reg;
    logic [COUNT_W-1:0]  out_total_reg;
    logic [TIME_W-1:0]   out_dur_reg;
    logic [DIST_W-1:0]   out_dist_reg;
    logic [SPEED_W-1:0]  out_speed_reg;

    // Decode of the latched item against the wheel state.
    logic [IDX_W-1:0]   idx;
    logic               wheel_ok;
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W-1:0]  dur;
    logic               poll_fire;
    logic               pulse;
    logic               arm;
    logic               in_hit;
    logic               out_load;
    logic               div_last;

    // Divider step.
    logic [TIME_W+1:0]  div_shift;
    logic [TIME_W+1:0]  div_diff;
    logic               div_fits;

    logic [SPEED_W-1:0] numer;
    logic [DIST_W-1:0]  dist_prod;

    always_comb
    begin
        idx       = IDX_W'(wheel_reg);
        wheel_ok  = int'(wheel_reg) < NUM_WHEELS;
        elapsed   = time_reg - last_reg[idx];
        dur       = time_reg - start_reg[idx];
        poll_fire = (cmd_reg == CMD_POLL) && due_reg[idx] && (elapsed >= idle_reg);
        pulse     = (cmd_reg == CMD_EDGE) && edge_any_reg && pending_reg[idx];
        arm       = (cmd_reg == CMD_EDGE) && edge_any_reg && !pending_reg[idx];
        div_last  = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        numer     = SPEED_W'(step_reg) * SPEED_W'(STEP_SCALE);
        dist_prod = {16'd0, total_reg} * {32'd0, step_reg};
    end

    // One restoring division step: shift in the next dividend bit, try the subtract.
    always_comb
    begin
        div_shift = {1'b0, rem_reg, quot_reg[SPEED_W-1]};
        div_diff  = div_shift - {2'b00, dur_reg};
        div_fits  = !div_diff[TIME_W+1];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_hit)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!wheel_ok)
                    state_next = ST_IDLE;
                else if (poll_fire)
                    state_next = ST_FINISH;
                else if (pulse)
                    state_next = (dur == '0) ? ST_FINISH : ST_DIV;
                else
                    state_next = ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        in_hit        = s_axis_tvalid && s_axis_tready;
        out_load      = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);
        m_axis_tvalid = out_valid_reg;
        m_axis_tuser  = OUT_USER_W'(out_kind_reg);
        m_axis_tdata  = {5'd0, out_speed_reg, out_dist_reg, out_dur_reg,
                         out_total_reg, out_wheel_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            idle_reg <= IDLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP: step_reg <= cfg_wdata[STEP_W-1:0];
                REG_IDLE: idle_reg <= cfg_wdata[TIME_W-1:0];
                default:  ;
            endcase
        end
    end

    // Input latch.
    always_ff @(posedge clk)
    begin
        if (in_hit)
        begin
            cmd_reg      <= s_axis_tuser[0];
            wheel_reg    <= s_axis_tdata[0];
            edge_any_reg <= s_axis_tdata[1] | s_axis_tdata[2];
            time_reg     <= s_axis_tdata[34:3];
        end
    end

    // Per-wheel state update, done once per item in the lookup cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            due_reg     <= '0;
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                start_reg[i] <= '0;
                count_reg[i] <= '0;
                last_reg[i]  <= '0;
            end
        end
        else if (state_reg == ST_EVAL && wheel_ok)
        begin
            if (arm)
            begin
                start_reg[idx]   <= time_reg;
                pending_reg[idx] <= 1'b1;
            end
            else if (pulse)
            begin
                count_reg[idx]   <= count_reg[idx] + 1'b1;
                last_reg[idx]    <= time_reg;
                due_reg[idx]     <= 1'b1;
                pending_reg[idx] <= 1'b0;
            end
            else if (poll_fire)
            begin
                due_reg[idx] <= 1'b0;
            end
        end
    end

    // Result fields and the divider.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EVAL)
        begin
            rem_reg <= '0;
            cnt_reg <= '0;
            if (cmd_reg == CMD_POLL)
            begin
                kind_reg  <= KIND_TOTAL;
                total_reg <= count_reg[idx];
                dur_reg   <= '0;
                quot_reg  <= '0;
            end
            else
            begin
                kind_reg  <= KIND_PULSE;
                total_reg <= count_reg[idx] + 1'b1;
                dur_reg   <= dur;
                quot_reg  <= (dur == '0) ? SPEED_MAX : numer;
            end
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg  <= div_fits ? div_diff[TIME_W-1:0] : div_shift[TIME_W-1:0];
            quot_reg <= {quot_reg[SPEED_W-2:0], div_fits};
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_kind_reg  <= kind_reg;
            out_wheel_reg <= wheel_reg;
            out_total_reg <= total_reg;
            out_dur_reg   <= dur_reg;
            out_dist_reg  <= dist_prod;
            out_speed_reg <= quot_reg;
        end
    end

endmodule

FILE: tb/wheel_encoder_speed_distance_tb.sv
`timescale 1ns / 100ps
// Testbench for wheel_encoder_speed_distance: directed and random encoder traffic
// checked against a behavioral predictor of pulse measurements and total reports.
// Depends on wesd_pkg and the wheel_encoder_speed_distance RTL.
module wheel_encoder_speed_distance_tb;
    import wesd_pkg::*;

    localparam int WHEELS        = 2;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_SHOWN     = 10;
    localparam logic [DIST_W-1:0] DIST_LIMIT = {DIST_W{1'b1}};

    typedef struct {
        logic              cmd;
        logic              wheel;
        logic              rise;
        logic              fall;
        logic [TIME_W-1:0] stamp;
    } enc_event_t;

    typedef struct {
        logic               kind;
        logic               wheel_id;
        logic [COUNT_W-1:0] total;
        logic [TIME_W-1:0]  duration;
        logic [DIST_W-1:0]  distance;
        logic [SPEED_W-1:0] speed;
    } enc_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [0] wheel, [1] rise flag, [2] fall flag, [34:3] time_us, rest zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [0] cmd
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    // [0] wheel_id, [32:1] pulse_total, [64:33] duration_us,
    // [112:65] distance_um, [138:113] speed_mm_s, rest zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [0] kind
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Predictor copy of the configuration and per-wheel state.
    logic [STEP_W-1:0]  model_step = STEP_RESET;
    logic [TIME_W-1:0]  model_idle = IDLE_RESET;
    logic               pair_open [WHEELS] = '{default: 1'b0};
    logic [TIME_W-1:0]  pair_start [WHEELS] = '{default: '0};
    logic [COUNT_W-1:0] pulse_cnt [WHEELS] = '{default: '0};
    logic [TIME_W-1:0]  last_stamp [WHEELS] = '{default: '0};
    logic               total_owed [WHEELS] = '{default: 1'b0};

    enc_report_t expected_reports [$];
    int err_cnt = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int idle_cycles = 0;

    wheel_encoder_speed_distance #(
        .NUM_WHEELS(WHEELS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [DIST_W-1:0] travel_um(logic [COUNT_W-1:0] count);
        logic [63:0] prod;
        prod = 64'(count) * 64'(model_step);
        return (prod > 64'(DIST_LIMIT)) ? DIST_LIMIT : prod[DIST_W-1:0];
    endfunction

    function automatic string report_str(enc_report_t r);
        return $sformatf("kind=%0d wheel=%0d total=%0d dur=%0d dist=%0d speed=%0d",
                         r.kind, r.wheel_id, r.total, r.duration, r.distance, r.speed);
    endfunction

    function automatic enc_event_t make_event(logic cmd, logic wheel, logic rise,
                                              logic fall, logic [TIME_W-1:0] stamp);
        enc_event_t ev;
        ev.cmd   = cmd;
        ev.wheel = wheel;
        ev.rise  = rise;
        ev.fall  = fall;
        ev.stamp = stamp;
        return ev;
    endfunction

    // Updates the wheel state for one accepted item and queues any result it gives.
    task automatic predict_encoder(enc_event_t ev);
        enc_report_t r;
        logic [TIME_W-1:0] dur;
        logic [63:0] quot;
        int w;
        w = int'(ev.wheel);
        if (ev.cmd == CMD_POLL)
        begin
            dur = ev.stamp - last_stamp[w];
            if (total_owed[w] && dur >= model_idle)
            begin
                total_owed[w] = 1'b0;
                r.kind     = KIND_TOTAL;
                r.wheel_id = ev.wheel;
                r.total    = pulse_cnt[w];
                r.duration = '0;
                r.distance = travel_um(pulse_cnt[w]);
                r.speed    = '0;
                expected_reports.push_back(r);
            end
        end
        else if (ev.rise || ev.fall)
        begin
            if (!pair_open[w])
            begin
                pair_start[w] = ev.stamp;
                pair_open[w]  = 1'b1;
            end
            else
            begin
                dur = ev.stamp - pair_start[w];
                if (dur == '0)
                    quot = 64'(SPEED_MAX);
                else
                    quot = (64'(model_step) * 64'd1000) / 64'(dur);
                if (quot > 64'(SPEED_MAX))
                    quot = 64'(SPEED_MAX);
                pulse_cnt[w]  = pulse_cnt[w] + 1'b1;
                last_stamp[w] = ev.stamp;
                total_owed[w] = 1'b1;
                pair_open[w]  = 1'b0;
                r.kind     = KIND_PULSE;
                r.wheel_id = ev.wheel;
                r.total    = pulse_cnt[w];
                r.duration = dur;
                r.distance = travel_um(pulse_cnt[w]);
                r.speed    = quot[SPEED_W-1:0];
                expected_reports.push_back(r);
            end
        end
    endtask

    // Valid stays high between back-to-back items; it only drops for an idle gap.
    task automatic send_event(enc_event_t ev);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({ev.stamp, ev.fall, ev.rise, ev.wheel});
        s_axis_tuser  <= ev.cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_encoder(ev);
    endtask

    // An item that gives no result may still be in flight, so wait a little longer.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(logic [STEP_W-1:0] step, logic [TIME_W-1:0] idle);
        cfg_we    <= 1'b1;
        cfg_index <= REG_STEP;
        cfg_wdata <= CFG_DATA_W'(step);
        @(posedge clk);
        cfg_index <= REG_IDLE;
        cfg_wdata <= idle;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_step = step;
        model_idle = idle;
    endtask

    task automatic test_defaults();
        send_event(make_event(CMD_POLL, 1'b0, 1'b0, 1'b0, 32'd5));
        send_event(make_event(CMD_EDGE, 1'b0, 1'b1, 1'b0, 32'd0));
        // Zero duration pins the speed at its maximum.
        send_event(make_event(CMD_EDGE, 1'b0, 1'b0, 1'b1, 32'd0));
        send_event(make_event(CMD_EDGE, 1'b0, 1'b0, 1'b0, 32'd123));
        send_event(make_event(CMD_EDGE, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFF0));
        send_event(make_event(CMD_EDGE, 1'b1, 1'b1, 1'b0, 32'h0000_0010));
        send_event(make_event(CMD_POLL, 1'b1, 1'b0, 1'b0, 32'h10 + 32'd1999999));
        send_event(make_event(CMD_POLL, 1'b1, 1'b1, 1'b1, 32'h10 + 32'd2000000));
        send_event(make_event(CMD_POLL, 1'b1, 1'b0, 1'b1, 32'h10 + 32'd2000000));
        send_event(make_event(CMD_EDGE, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF));
        send_event(make_event(CMD_EDGE, 1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF));
        send_event(make_event(CMD_POLL, 1'b0, 1'b1, 1'b0, 32'h7FFF_FFFF + 32'd2000000));
    endtask

    task automatic test_step_extremes();
        drain_results();
        write_settings('0, '0);
        send_event(make_event(CMD_EDGE, 1'b0, 1'b1, 1'b0, 32'd5));
        send_event(make_event(CMD_EDGE, 1'b0, 1'b0, 1'b1, 32'd1005));
        // With no idle interval the report is owed at once.
        send_event(make_event(CMD_POLL, 1'b0, 1'b0, 1'b0, 32'd1005));
        send_event(make_event(CMD_EDGE, 1'b1, 1'b1, 1'b0, 32'd9));
        send_event(make_event(CMD_EDGE, 1'b1, 1'b1, 1'b0, 32'd9));
        drain_results();
        write_settings({STEP_W{1'b1}}, {TIME_W{1'b1}});
        send_event(make_event(CMD_EDGE, 1'b0, 1'b1, 1'b0, 32'd100));
        send_event(make_event(CMD_EDGE, 1'b0, 1'b0, 1'b1, 32'd101));
        send_event(make_event(CMD_POLL, 1'b0, 1'b0, 1'b0, 32'd99));
        send_event(make_event(CMD_POLL, 1'b0, 1'b0, 1'b0, 32'd100));
        send_event(make_event(CMD_EDGE, 1'b1, 1'b1, 1'b1, 32'd1));
        send_event(make_event(CMD_EDGE, 1'b1, 1'b0, 1'b1, 32'd0));
    endtask

    // Mostly well-formed edge pairs on a running clock, polls aimed at the idle
    // threshold or at the current time, and some fully random items.
    task automatic test_random_traffic(int n, int idle_pct, int stall, logic [STEP_W-1:0] step,
                                       logic [TIME_W-1:0] idle, int adv_max);
        enc_event_t ev;
        logic [1:0] flags;
        logic [TIME_W-1:0] t_now;
        int count;
        int pick;
        drain_results();
        write_settings(step, idle);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        t_now = $urandom;
        count = 0;
        while (count < n)
        begin
            ev.wheel = 1'($urandom_range(1));
            ev.rise  = 1'($urandom_range(1));
            ev.fall  = 1'($urandom_range(1));
            if ($urandom_range(99) < 15)
            begin
                ev.cmd   = 1'($urandom_range(1));
                ev.stamp = $urandom;
            end
            else if ($urandom_range(99) < 25)
            begin
                ev.cmd = CMD_POLL;
                pick = $urandom_range(9);
                if (pick < 3)
                    ev.stamp = last_stamp[ev.wheel] + model_idle;
                else if (pick == 3)
                    ev.stamp = last_stamp[ev.wheel] + model_idle - 1'b1;
                else
                    ev.stamp = t_now;
            end
            else
            begin
                ev.cmd = CMD_EDGE;
                flags = 2'($urandom_range(1, 3));
                ev.rise = flags[0];
                ev.fall = flags[1];
                if ($urandom_range(19) != 0)
                    t_now = t_now + $urandom_range(0, adv_max);
                ev.stamp = t_now;
            end
            send_event(ev);
            if (!(ev.cmd == CMD_EDGE && !ev.rise && !ev.fall))
                count++;
        end
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : check_results
        enc_report_t got;
        enc_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind     = m_axis_tuser[0];
            got.wheel_id = m_axis_tdata[0];
            got.total    = m_axis_tdata[32:1];
            got.duration = m_axis_tdata[64:33];
            got.distance = m_axis_tdata[112:65];
            got.speed    = m_axis_tdata[138:113];
            if (expected_reports.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_SHOWN)
                    $display("%0t: result with none expected: %s", $realtime, report_str(got));
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.kind !== want.kind || got.wheel_id !== want.wheel_id ||
                    got.total !== want.total || got.duration !== want.duration ||
                    got.distance !== want.distance || got.speed !== want.speed)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_SHOWN)
                        $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                                 report_str(want), report_str(got));
                end
            end
        end
    end

    // Ends a hung run: too many cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_step_extremes();
        test_random_traffic(230, 0, 0, 16'($urandom_range(1, 65535)),
                            $urandom_range(100, 5000), 3000);
        test_random_traffic(230, 52, 0, 16'd1, 32'd1, 40);
        test_random_traffic(230, 0, 52, {STEP_W{1'b1}}, {TIME_W{1'b1}}, 100000);
        test_random_traffic(230, 22, 22, 16'($urandom_range(1, 65535)),
                            $urandom_range(1, 200000), 150000);
        drain_results();
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/wesd_pkg.sv
hdl/wheel_encoder_speed_distance.sv
tb/wheel_encoder_speed_distance_tb.sv
